/* design/mbe_pkg.sv */
// Package for the minimum bottleneck edge weight unit.
// Holds widths, capacities, state encodings and the control structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mbe_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int MAX_EDGES    = 4096;
    localparam int VTX_W        = $clog2(MAX_VERTICES);
    localparam int VCNT_W       = VTX_W + 1;
    localparam int EADDR_W      = $clog2(MAX_EDGES);
    localparam int ECNT_W       = EADDR_W + 1;
    localparam int WGT_W        = 20;
    localparam int BIT_W        = 5;
    localparam int RANK_W       = 4;
    localparam int EDGE_W       = WGT_W + 2 * VTX_W;
    localparam logic [RANK_W-1:0] RANK_MAX = '1;

    typedef struct packed {
        logic              start;
        logic [WGT_W-1:0]  thr;
        logic [VCNT_W-1:0] n;
        logic [ECNT_W-1:0] total;
    } t_uf_req;

    typedef struct packed {
        logic done;
        logic connected;
    } t_uf_rsp;

    typedef enum logic [3:0] {
        U_IDLE, U_INIT, U_EDGE_RD, U_EDGE_CHK, U_FIND_RD, U_FIND_CHK,
        U_RANK_A, U_RANK_B, U_LINK, U_RANK_INC, U_DONE
    } t_uf_state;

    typedef enum logic [2:0] {
        T_IDLE, T_FULL, T_FULL_WAIT, T_BIT, T_BIT_WAIT, T_RESULT
    } t_top_state;

endpackage

`default_nettype wire

/* design/mbe_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mbe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* design/mbe_uf.sv */
// Union-find connectivity pass: joins every stored edge whose weight is at
// most a threshold and reports whether one component remains.
// Depends on mbe_pkg and mbe_ram.
`timescale 1ns / 1ps
`default_nettype none

module mbe_uf
    import mbe_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_uf_req             i_req,
    output t_uf_rsp                  o_rsp,
    output logic [EADDR_W-1:0]       o_edge_raddr,
    input  wire logic [EDGE_W-1:0]   i_edge_rdata
);

    t_uf_state r_state, n_state;

    logic [ECNT_W-1:0] r_eidx, n_eidx;
    logic [VCNT_W-1:0] r_v, n_v;
    logic [VTX_W-1:0]  r_x, n_x;
    logic [VTX_W-1:0]  r_b, n_b;
    logic [VTX_W-1:0]  r_ra, n_ra;
    logic [VTX_W-1:0]  r_rb, n_rb;
    logic              r_second, n_second;
    logic [RANK_W-1:0] r_rka, n_rka;
    logic [VCNT_W-1:0] r_unions, n_unions;

    logic              p_we;
    logic [VTX_W-1:0]  p_waddr, p_wdata, p_raddr, p_rdata;
    logic              k_we;
    logic [VTX_W-1:0]  k_waddr, k_raddr;
    logic [RANK_W-1:0] k_wdata, k_rdata;

    logic [WGT_W-1:0]  e_w;
    logic [VTX_W-1:0]  e_a, e_b;
    logic [VCNT_W-1:0] last_vtx;

    assign e_w      = i_edge_rdata[EDGE_W-1 -: WGT_W];
    assign e_a      = i_edge_rdata[2*VTX_W-1 -: VTX_W];
    assign e_b      = i_edge_rdata[VTX_W-1:0];
    assign last_vtx = i_req.n - VCNT_W'(1);

    mbe_ram #(.WIDTH(VTX_W), .DEPTH(MAX_VERTICES)) u_parent (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_waddr), .i_wdata(p_wdata),
        .i_raddr(p_raddr), .o_rdata(p_rdata)
    );

    mbe_ram #(.WIDTH(RANK_W), .DEPTH(MAX_VERTICES)) u_rank (
        .i_clk(i_clk), .i_we(k_we), .i_waddr(k_waddr), .i_wdata(k_wdata),
        .i_raddr(k_raddr), .o_rdata(k_rdata)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            U_IDLE:     if (i_req.start) n_state = U_INIT;
            U_INIT:     if (r_v == last_vtx) n_state = U_EDGE_RD;
            U_EDGE_RD:  n_state = (r_eidx == i_req.total) ? U_DONE : U_EDGE_CHK;
            U_EDGE_CHK: n_state = (e_w > i_req.thr) ? U_EDGE_RD : U_FIND_RD;
            U_FIND_RD:  n_state = U_FIND_CHK;
            U_FIND_CHK: begin
                if (p_rdata != r_x) begin
                    n_state = U_FIND_RD;
                end else if (!r_second) begin
                    n_state = U_FIND_RD;
                end else begin
                    n_state = (r_ra == r_x) ? U_EDGE_RD : U_RANK_A;
                end
            end
            U_RANK_A:   n_state = U_RANK_B;
            U_RANK_B:   n_state = U_LINK;
            U_LINK: begin
                if (r_rka == k_rdata && r_rka != RANK_MAX) begin
                    n_state = U_RANK_INC;
                end else begin
                    n_state = U_EDGE_RD;
                end
            end
            U_RANK_INC: n_state = U_EDGE_RD;
            U_DONE:     n_state = U_IDLE;
            default:    n_state = U_IDLE;
        endcase
    end

    // Datapath registers.
    always_comb begin
        n_eidx   = r_eidx;
        n_v      = r_v;
        n_x      = r_x;
        n_b      = r_b;
        n_ra     = r_ra;
        n_rb     = r_rb;
        n_second = r_second;
        n_rka    = r_rka;
        n_unions = r_unions;
        case (r_state)
            U_IDLE: begin
                n_v      = '0;
                n_eidx   = '0;
                n_unions = '0;
            end
            U_INIT:     n_v = r_v + VCNT_W'(1);
            U_EDGE_CHK: begin
                if (e_w > i_req.thr) begin
                    n_eidx = r_eidx + ECNT_W'(1);
                end
                n_x      = e_a;
                n_b      = e_b;
                n_second = 1'b0;
            end
            U_FIND_CHK: begin
                if (p_rdata != r_x) begin
                    n_x = p_rdata;
                end else if (!r_second) begin
                    n_ra     = r_x;
                    n_x      = r_b;
                    n_second = 1'b1;
                end else begin
                    n_rb = r_x;
                    if (r_ra == r_x) begin
                        n_eidx = r_eidx + ECNT_W'(1);
                    end
                end
            end
            U_RANK_B:   n_rka = k_rdata;
            U_LINK: begin
                n_unions = r_unions + VCNT_W'(1);
                n_eidx   = r_eidx + ECNT_W'(1);
            end
            default: ;
        endcase
    end

    // Memory controls and response.
    always_comb begin
        p_we    = 1'b0;
        p_waddr = r_v[VTX_W-1:0];
        p_wdata = r_v[VTX_W-1:0];
        p_raddr = r_x;
        k_we    = 1'b0;
        k_waddr = r_v[VTX_W-1:0];
        k_wdata = '0;
        k_raddr = r_ra;
        case (r_state)
            U_INIT: begin
                p_we = 1'b1;
                k_we = 1'b1;
            end
            U_RANK_B: k_raddr = r_rb;
            U_LINK: begin
                p_we = 1'b1;
                if (r_rka < k_rdata) begin
                    p_waddr = r_ra;
                    p_wdata = r_rb;
                end else begin
                    p_waddr = r_rb;
                    p_wdata = r_ra;
                end
            end
            U_RANK_INC: begin
                k_we    = 1'b1;
                k_waddr = r_ra;
                k_wdata = r_rka + RANK_W'(1);
            end
            default: ;
        endcase
        o_edge_raddr    = r_eidx[EADDR_W-1:0];
        o_rsp.done      = (r_state == U_DONE);
        o_rsp.connected = (r_unions == last_vtx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_eidx   <= n_eidx;
        r_v      <= n_v;
        r_x      <= n_x;
        r_b      <= n_b;
        r_ra     <= n_ra;
        r_rb     <= n_rb;
        r_second <= n_second;
        r_rka    <= n_rka;
        r_unions <= n_unions;
    end

endmodule

`default_nettype wire

/* design/mst_bottleneck_edge_weight_unit.sv */
// Minimum bottleneck spanning tree weight: top level with edge loader and search control.
// Edge transactions are taken only while idle; a last transaction is answered after up to
// 21 union-find passes: one full pass and, if that one connects, one per weight bit.
// Throughput: one edge per cycle while loading, one graph at a time while solving.
// Reset (synchronous, active low) empties the edge store and sets vertex_count to 1.
// Depends on mbe_pkg, mbe_ram and mbe_uf.
`timescale 1ns / 1ps
`default_nettype none

module mst_bottleneck_edge_weight_unit
    import mbe_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [VCNT_W-1:0] i_cfg_data,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic              i_edge_present,
    input  wire logic [VTX_W-1:0]  i_end_a,
    input  wire logic [VTX_W-1:0]  i_end_b,
    input  wire logic [WGT_W-1:0]  i_weight,
    input  wire logic              i_last_edge,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [WGT_W-1:0]       o_bottleneck,
    output logic                   o_connected,
    output logic                   o_overflow
);

    // The bottleneck of a minimum spanning tree equals the smallest threshold
    // at which the edges no heavier than it connect the graph. A first pass over
    // all edges decides connectivity; then the threshold is found one bit at a
    // time, most significant first, with one union-find pass per bit.

    t_top_state r_state, n_state;

    logic [VCNT_W-1:0] r_vcount;
    logic [ECNT_W-1:0] r_total;
    logic              r_dropped;
    logic [WGT_W-1:0]  r_t;
    logic [BIT_W-1:0]  r_bit;
    logic              r_res_conn;
    logic [WGT_W-1:0]  r_res_w;
    logic              r_out_valid;
    logic [WGT_W-1:0]  r_out_w;
    logic              r_out_conn;
    logic              r_out_ovf;

    logic [VCNT_W-1:0]  eff_n;
    logic               in_take;
    logic               in_range;
    logic               store_we;
    logic               out_free;
    logic [WGT_W-1:0]   bit_val;
    logic [WGT_W-1:0]   bit_mask;
    logic [EADDR_W-1:0] edge_raddr;
    logic [EDGE_W-1:0]  edge_rdata;
    t_uf_req            uf_req;
    t_uf_rsp            uf_rsp;

    // A vertex count of zero acts as one, and one above capacity as capacity.
    always_comb begin
        if (r_vcount == '0) begin
            eff_n = VCNT_W'(1);
        end else if (r_vcount > VCNT_W'(MAX_VERTICES)) begin
            eff_n = VCNT_W'(MAX_VERTICES);
        end else begin
            eff_n = r_vcount;
        end
    end

    assign o_stall  = (r_state != T_IDLE);
    assign in_take  = i_valid && !o_stall;
    assign in_range = ({1'b0, i_end_a} < eff_n) && ({1'b0, i_end_b} < eff_n);
    assign store_we = in_take && i_edge_present && in_range
                      && (r_total < ECNT_W'(MAX_EDGES));
    assign out_free = !r_out_valid || !i_stall;
    assign bit_val  = WGT_W'(1) << r_bit;
    assign bit_mask = bit_val - WGT_W'(1);

    mbe_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edges (
        .i_clk(i_clk), .i_we(store_we), .i_waddr(r_total[EADDR_W-1:0]),
        .i_wdata({i_weight, i_end_a, i_end_b}),
        .i_raddr(edge_raddr), .o_rdata(edge_rdata)
    );

    // The threshold must hold for the whole pass, so the full pass keeps the
    // open threshold while it waits as well.
    always_comb begin
        uf_req.start = (r_state == T_FULL) || (r_state == T_BIT);
        uf_req.thr   = (r_state == T_FULL || r_state == T_FULL_WAIT) ? '1
                                                                      : (r_t | bit_mask);
        uf_req.n     = eff_n;
        uf_req.total = r_total;
    end

    mbe_uf u_uf (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(uf_req), .o_rsp(uf_rsp),
        .o_edge_raddr(edge_raddr), .i_edge_rdata(edge_rdata)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            T_IDLE: begin
                if (in_take && i_last_edge) begin
                    n_state = (eff_n == VCNT_W'(1)) ? T_RESULT : T_FULL;
                end
            end
            T_FULL:      n_state = T_FULL_WAIT;
            T_FULL_WAIT: begin
                if (uf_rsp.done) begin
                    n_state = uf_rsp.connected ? T_BIT : T_RESULT;
                end
            end
            T_BIT:       n_state = T_BIT_WAIT;
            T_BIT_WAIT: begin
                if (uf_rsp.done) begin
                    n_state = (r_bit == '0) ? T_RESULT : T_BIT;
                end
            end
            T_RESULT:    if (out_free) n_state = T_IDLE;
            default:     n_state = T_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_vcount    <= VCNT_W'(1);
            r_total     <= '0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_vcount <= i_cfg_data;
            end
            if (store_we) begin
                r_total <= r_total + ECNT_W'(1);
            end else if (in_take && i_edge_present && in_range) begin
                r_dropped <= 1'b1;
            end
            if (r_state == T_RESULT && out_free) begin
                r_out_valid <= 1'b1;
                r_total     <= '0;
                r_dropped   <= 1'b0;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end

        case (r_state)
            T_IDLE: begin
                r_t        <= '0;
                r_bit      <= BIT_W'(WGT_W - 1);
                r_res_conn <= 1'b1;
                r_res_w    <= '0;
            end
            T_FULL_WAIT: begin
                if (uf_rsp.done) begin
                    r_res_conn <= uf_rsp.connected;
                end
            end
            T_BIT_WAIT: begin
                if (uf_rsp.done) begin
                    // Threshold failed: this bit of the answer must be set.
                    if (!uf_rsp.connected) begin
                        r_t     <= r_t | bit_val;
                        r_res_w <= r_t | bit_val;
                    end else begin
                        r_res_w <= r_t;
                    end
                    r_bit <= r_bit - BIT_W'(1);
                end
            end
            default: ;
        endcase

        if (r_state == T_RESULT && out_free) begin
            r_out_w    <= r_res_conn ? r_res_w : '0;
            r_out_conn <= r_res_conn;
            r_out_ovf  <= r_dropped;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_bottleneck = r_out_w;
    assign o_connected  = r_out_conn;
    assign o_overflow   = r_out_ovf;

endmodule

`default_nettype wire

/* tb/mbe_checker.sv */
// Scoreboard for the bottleneck spanning tree unit: watches both channels and the register port.
// Rebuilds each graph, solves it with Kruskal's method and compares each result field by field.
// Depends on mbe_pkg.
`timescale 1ns / 1ps

module mbe_checker
    import mbe_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [VCNT_W-1:0] i_cfg_data,
    input  logic              i_valid,
    input  logic              i_stall_in,
    input  logic              i_edge_present,
    input  logic [VTX_W-1:0]  i_end_a,
    input  logic [VTX_W-1:0]  i_end_b,
    input  logic [WGT_W-1:0]  i_weight,
    input  logic              i_last_edge,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [WGT_W-1:0]  i_bottleneck,
    input  logic              i_connected,
    input  logic              i_overflow,
    output int                o_errors,
    output int                o_pending
);

    typedef struct packed {
        logic [WGT_W-1:0] bneck;
        logic             conn;
        logic             ovf;
    } t_tree_result;

    logic [EDGE_W-1:0] graph_edges[$];
    t_tree_result      tree_results[$];
    logic [VCNT_W-1:0] vcount;
    logic              dropped;
    int                leader[MAX_VERTICES];

    function automatic int eff_count(logic [VCNT_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_VERTICES) return MAX_VERTICES;
        return int'(v);
    endfunction

    function automatic int find_root(int v);
        while (leader[v] != v) begin
            leader[v] = leader[leader[v]];
            v = leader[v];
        end
        return v;
    endfunction

    // Kruskal over the stored edges; keys sort by weight in the top bits.
    function automatic t_tree_result solve_tree(int nv, logic ovf);
        t_tree_result res;
        int comps, ra, rb;
        logic [WGT_W-1:0] best;
        best = '0;
        comps = nv;
        for (int i = 0; i < nv; i++) leader[i] = i;
        graph_edges.sort();
        foreach (graph_edges[i]) begin
            ra = find_root(int'(graph_edges[i][2*VTX_W-1:VTX_W]));
            rb = find_root(int'(graph_edges[i][VTX_W-1:0]));
            if (ra != rb) begin
                leader[ra] = rb;
                comps--;
                if (graph_edges[i][EDGE_W-1:2*VTX_W] > best)
                    best = graph_edges[i][EDGE_W-1:2*VTX_W];
            end
        end
        res.conn = (comps == 1);
        res.bneck = res.conn ? best : '0;
        res.ovf = ovf;
        return res;
    endfunction

    assign o_pending = tree_results.size();

    always @(posedge i_clk) begin
        t_tree_result exp_r;
        int nv;
        if (!i_rst_n) begin
            vcount <= 1;
            dropped = 1'b0;
            graph_edges.delete();
            tree_results.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_we) vcount <= i_cfg_data;
            if (i_valid && !i_stall_in) begin
                nv = eff_count(vcount);
                if (i_edge_present && i_end_a < nv && i_end_b < nv) begin
                    if (graph_edges.size() < MAX_EDGES)
                        graph_edges.insert(graph_edges.size(),
                                           {i_weight, i_end_a, i_end_b});
                    else
                        dropped = 1'b1;
                end
                if (i_last_edge) begin
                    tree_results.insert(tree_results.size(), solve_tree(nv, dropped));
                    graph_edges.delete();
                    dropped = 1'b0;
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (tree_results.size() == 0) begin
                    if (o_errors < 10)
                        $display("unexpected result: bneck=%0d conn=%0b ovf=%0b",
                                 i_bottleneck, i_connected, i_overflow);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = tree_results.pop_front();
                    if (exp_r != {i_bottleneck, i_connected, i_overflow}) begin
                        if (o_errors < 10)
                            $display("mismatch: exp bneck=%0d conn=%0b ovf=%0b, got %0d %0b %0b",
                                     exp_r.bneck, exp_r.conn, exp_r.ovf,
                                     i_bottleneck, i_connected, i_overflow);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

/* tb/tb_top.sv */
// Top of the bottleneck spanning tree unit testbench: clock, reset, stimulus and verdict.
// Prediction and checking live in mbe_checker; depends on mbe_pkg and the design.
`timescale 1ns / 1ps

module tb_top;
    import mbe_pkg::*;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [VCNT_W-1:0] cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              edge_present = 1'b0;
    logic [VTX_W-1:0]  end_a = '0;
    logic [VTX_W-1:0]  end_b = '0;
    logic [WGT_W-1:0]  weight = '0;
    logic              last_edge = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [WGT_W-1:0]  bottleneck;
    logic              connected;
    logic              overflow;
    int                errors;
    int                pending;

    int burst_left = 0;
    int items_sent = 0;
    int cur_vertices = 1;

    always #5 i_clk = ~i_clk;

    mst_bottleneck_edge_weight_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_edge_present(edge_present), .i_end_a(end_a), .i_end_b(end_b),
        .i_weight(weight), .i_last_edge(last_edge),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_bottleneck(bottleneck), .o_connected(connected), .o_overflow(overflow)
    );

    mbe_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .i_stall_in(in_stall),
        .i_edge_present(edge_present), .i_end_a(end_a), .i_end_b(end_b),
        .i_weight(weight), .i_last_edge(last_edge),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_bottleneck(bottleneck), .i_connected(connected), .i_overflow(overflow),
        .o_errors(errors), .o_pending(pending)
    );

    // The receiver switches among four stall patterns: none at all, light random
    // stalls, heavy random stalls and very heavy random stalls. The pattern changes now and then.
    int stall_mode = 0;
    always @(posedge i_clk) begin
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: begin
                out_stall <= 1'b0;
            end
            1: begin
                out_stall <= ($urandom_range(0, 3) == 0);
            end
            2: begin
                out_stall <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                out_stall <= ($urandom_range(0, 15) < 14);
            end
        endcase
    end

    // Offers one transaction and returns right after the edge that accepts it.
    // The sender works in bursts; between bursts valid may drop for a random gap.
    task automatic send(input logic p, input int a, input int b,
                        input logic [WGT_W-1:0] w, input logic l);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        edge_present <= p;
        end_a <= a[VTX_W-1:0];
        end_b <= b[VTX_W-1:0];
        weight <= w;
        last_edge <= l;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        items_sent++;
    endtask

    // Register writes happen only with the block idle: every expected result is in,
    // then a short pause covers any item still draining through the loader.
    task automatic set_vertices(input int v);
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_data <= v[VCNT_W-1:0];
        @(posedge i_clk);
        cfg_we <= 1'b0;
        cur_vertices = (v == 0) ? 1 : (v > MAX_VERTICES) ? MAX_VERTICES : v;
    endtask

    // One graph of random edges. Most transactions are well-formed edges; a few carry
    // endpoints drawn from the whole index range or no edge at all. Weights are either the full
    // range or a narrow one so that equal weights show up often.
    task automatic random_graph();
        int k;
        int top;
        logic narrow;
        logic [WGT_W-1:0] w;
        k = $urandom_range(0, 12);
        top = cur_vertices - 1;
        narrow = $urandom_range(0, 1);
        for (int i = 0; i < k; i++) begin
            w = narrow ? WGT_W'($urandom_range(0, 7)) : WGT_W'($urandom);
            case ($urandom_range(0, 19))
                0: send(1'b1, $urandom_range(0, 1023), $urandom_range(0, 1023), w, 1'b0);
                1: send(1'b0, $urandom_range(0, 1023), $urandom_range(0, 1023), w, 1'b0);
                default: send(1'b1, $urandom_range(0, top), $urandom_range(0, top), w, 1'b0);
            endcase
        end
        if ($urandom_range(0, 1))
            send(1'b1, $urandom_range(0, top), $urandom_range(0, top),
                 WGT_W'($urandom), 1'b1);
        else
            send(1'b0, $urandom_range(0, 1023), $urandom_range(0, 1023),
                 WGT_W'($urandom), 1'b1);
    endtask

    initial begin
        int vlist[8];
        vlist = '{2, 3, 4, 5, 8, 16, 1024, 2047};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single vertex at the reset setting: a bare end marker is connected with weight 0.
        send(1'b0, 0, 0, '0, 1'b1);
        // A vertex count of zero acts as one; a self loop with the largest weight still
        // leaves the bottleneck at zero, and an out-of-range edge is dropped quietly.
        set_vertices(0);
        send(1'b1, 0, 1, 20'd5, 1'b0);
        send(1'b1, 0, 0, 20'hFFFFF, 1'b1);
        // Four vertices: extreme weights, a self loop, endpoints at the top of the
        // index range, an item with neither edge nor end mark, last item carrying an edge.
        set_vertices(4);
        send(1'b1, 0, 1, 20'h00000, 1'b0);
        send(1'b1, 2, 2, 20'h00001, 1'b0);
        send(1'b1, 1023, 1, 20'h00002, 1'b0);
        send(1'b1, 3, 1023, 20'h00002, 1'b0);
        send(1'b0, 1, 2, 20'h00003, 1'b0);
        send(1'b1, 1, 2, 20'hFFFFF, 1'b0);
        send(1'b1, 3, 2, 20'h7FFFF, 1'b1);
        // Same count, but vertex 3 is never reached: not connected, bottleneck zero.
        send(1'b1, 0, 1, 20'hAAAAA, 1'b0);
        send(1'b1, 1, 2, 20'h55555, 1'b0);
        send(1'b0, 0, 0, '0, 1'b1);
        // Counts above the vertex limit act as the limit itself.
        set_vertices(2047);
        send(1'b1, 1023, 0, 20'h12345, 1'b0);
        send(1'b1, 512, 1023, 20'h54321, 1'b1);

        // Store overflow: two vertices and one edge more than the store holds.
        set_vertices(2);
        for (int i = 0; i <= MAX_EDGES; i++)
            send(1'b1, $urandom_range(0, 1), $urandom_range(0, 1),
                 WGT_W'($urandom_range(0, 3)), 1'b0);
        send(1'b0, 0, 0, '0, 1'b1);
        // The next graph must start clean with no overflow carried over.
        send(1'b1, 0, 1, 20'd9, 1'b1);

        // Random phases, each with its own vertex count.
        items_sent = 0;
        while (items_sent < 1650) begin
            if ($urandom_range(0, 2) == 0)
                set_vertices($urandom_range(1, 12));
            else
                set_vertices(vlist[$urandom_range(0, 7)]);
            repeat ($urandom_range(4, 14)) random_graph();
        end

        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // The overflow graph dominates the run time; this bound is many times over it.
    initial begin
        #200ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* files.f */
design/mbe_pkg.sv
design/mbe_ram.sv
design/mbe_uf.sv
design/mst_bottleneck_edge_weight_unit.sv
tb/mbe_checker.sv
tb/tb_top.sv
